// ===== hw/rtl/pdios_pkg.sv =====
// pdios_pkg: shared constants, codes, entry layout and state type of the
// priority deadline i/o scheduler. No dependencies.
package pdios_pkg;

  localparam int TAG_COUNT   = 64;
  localparam int SECTOR_BITS = 48;
  localparam int TAG_W       = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int TICK_RATE   = 100;
  localparam int QUEUES      = 6;
  localparam int Q_W         = 3;

  localparam logic [30:0] READ_EXPIRE_RST  = 31'(TICK_RATE / 2);
  localparam logic [30:0] WRITE_EXPIRE_RST = 31'(5 * TICK_RATE);

  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_DISPATCH = 3'd1;
  localparam logic [2:0] MODE_LOOKUP   = 3'd2;
  localparam logic [2:0] MODE_REMOVE   = 3'd3;
  localparam logic [2:0] MODE_UPDATE   = 3'd4;

  localparam logic [1:0] CFG_READ_EXPIRE  = 2'd0;
  localparam logic [1:0] CFG_WRITE_EXPIRE = 2'd1;
  localparam logic [1:0] CFG_FRONT_MERGE  = 2'd2;

  localparam logic [1:0] MERGE_NONE    = 2'd0;
  localparam logic [1:0] MERGE_FRONT   = 2'd1;
  localparam logic [1:0] MERGE_DISCARD = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] start;
    logic                   write;
    logic [1:0]             level;
    logic [31:0]            deadline;
    logic [31:0]            order;
    logic [1:0]             flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       hit;
    logic [5:0] tag;
    logic [1:0] kind;
    logic       bydl;
  } res_t;

  // realtime is level 0, none and best effort level 1, idle level 2
  function automatic logic [1:0] class_to_level(input logic [1:0] cls);
    logic [1:0] lvl;
    case (cls)
      2'd1: lvl = 2'd0;
      2'd3: lvl = 2'd2;
      default: lvl = 2'd1;
    endcase
    return lvl;
  endfunction

endpackage

// ===== hw/rtl/pdios_if.sv =====
// pdios_in_if / pdios_out_if: valid-ready channels of the scheduler.
// Depends on nothing.
interface pdios_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [5:0]  request_tag;
  logic [47:0] start_sector;
  logic        is_write;
  logic [1:0]  io_class;
  logic        insert_at_head;
  logic        is_mergeable;
  logic        is_discard;
  logic [47:0] lookup_sector;
  logic [31:0] current_time;

  modport source (output valid, mode, request_tag, start_sector, is_write, io_class,
                  insert_at_head, is_mergeable, is_discard, lookup_sector,
                  current_time, input ready);
  modport sink (input valid, mode, request_tag, start_sector, is_write, io_class,
                insert_at_head, is_mergeable, is_discard, lookup_sector,
                current_time, output ready);
endinterface

interface pdios_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [5:0] out_tag;
  logic [1:0] merge_kind;
  logic       by_deadline;
  logic       work_pending;

  modport source (output valid, hit, out_tag, merge_kind, by_deadline, work_pending,
                  input ready);
  modport sink (input valid, hit, out_tag, merge_kind, by_deadline, work_pending,
                output ready);
endinterface

// ===== hw/rtl/priority_deadline_io_scheduler_core.sv =====
// priority_deadline_io_scheduler_core: top level of the deadline scheduler.
// Depends on pdios_pkg, pdios_in_if / pdios_out_if and pdios_ram.
//
// Usage:
//   in_if carries one command word (insert, dispatch, merge lookup, remove,
//   update start); out_if returns exactly one result word per command.
//   cfg_we/cfg_index/cfg_wdata write the read expiry (0), the write expiry (1)
//   and the front merge enable (2); write them only while the block is idle.
//   Request entries live in one ram of TAG_COUNT words; valid bits sit in
//   flip-flops, so no clearing pass is needed after reset.
//   Insert, remove and unknown modes load the result register directly;
//   update start reads the entry, then writes it back; dispatch and merge
//   lookup scan the ram, reading one entry per cycle, then load the result
//   in a finish state. One command is in flight at a time and the result
//   word must leave before the next command is taken.
//   A new command is taken once the previous result has left the output
//   register; while out_if.ready is low the result holds and in_if.ready
//   stays low.
//   Reset (rst_n low, synchronous) empties all queues, sets head order 0,
//   tail order 1 and restores the default expiry and merge settings.
module priority_deadline_io_scheduler_core
  import pdios_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pdios_in_if.sink    in_if,
  pdios_out_if.source out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [2:0]             mode_r;
  logic [TAG_W-1:0]       tag_r;
  logic [SECTOR_BITS-1:0] start_r;
  logic                   dir_r;
  logic [1:0]             lvl_r;
  logic [SECTOR_BITS-1:0] key_r;
  logic [31:0]            now_r;
  logic [TAG_W-1:0]       idx_r;

  logic [TAG_COUNT-1:0] valid_r, valid_nxt;
  logic [31:0]          head_cnt_r, tail_cnt_r;
  logic [30:0]          read_exp_r, write_exp_r;
  logic                 fm_en_r;

  // per queue trackers: fifo head and lowest sector
  logic [QUEUES-1:0]      qv_r;
  logic [TAG_W-1:0]       htag_r   [QUEUES];
  logic [31:0]            hpos_r   [QUEUES];
  logic [31:0]            hdl_r    [QUEUES];
  logic [TAG_W-1:0]       ltag_r   [QUEUES];
  logic [SECTOR_BITS-1:0] lstart_r [QUEUES];
  logic [31:0]            lpos_r   [QUEUES];

  // merge lookup tracker
  logic             bv_r;
  logic [TAG_W-1:0] btag_r;
  logic [31:0]      bpos_r;
  logic             bdisc_r;

  logic out_valid_r;
  res_t res_r, res;
  logic res_load;
  logic out_pending_r;

  logic             ram_we;
  logic [TAG_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic             accept;
  logic             tag_ok;
  logic [TAG_W-1:0] in_tag;
  logic [1:0]       in_lvl;
  logic [31:0]      pos;
  logic [Q_W-1:0]   eq;
  logic             ev;
  logic             last;

  logic             sel_found;
  logic [Q_W-1:0]   sel_q;
  logic [31:0]      age;
  logic             expired;

  pdios_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TAG_COUNT)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign accept      = in_if.valid && in_if.ready;
  assign tag_ok      = 32'(in_if.request_tag) < TAG_COUNT;
  assign in_tag      = TAG_W'(in_if.request_tag);
  assign in_lvl      = class_to_level(in_if.io_class);

  // scan word: entry idx_r arrives from the ram this cycle
  assign pos  = ram_rdata.order - head_cnt_r - 32'd1;
  assign eq   = {ram_rdata.level, ram_rdata.write};
  assign ev   = valid_r[idx_r];
  assign last = (idx_r == TAG_W'(TAG_COUNT - 1));

  always_comb begin
    sel_found = 1'b0;
    sel_q     = '0;
    for (int q = QUEUES - 1; q >= 0; q--) begin
      if (qv_r[q]) begin
        sel_found = 1'b1;
        sel_q     = Q_W'(q);
      end
    end
  end

  assign age     = now_r - hdl_r[sel_q];
  assign expired = ~age[31];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_if.mode == MODE_DISPATCH || in_if.mode == MODE_LOOKUP) begin
            state_nxt = ST_SCAN;
          end else if (in_if.mode == MODE_UPDATE && tag_ok && valid_r[in_tag]) begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD:  state_nxt = ST_IDLE;
      ST_SCAN: if (last) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: ram control, valid bits and result word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_tag;
    ram_wdata = ram_rdata;
    ram_raddr = in_tag;
    valid_nxt = valid_r;
    res_load  = 1'b0;
    res       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_if.mode == MODE_DISPATCH || in_if.mode == MODE_LOOKUP) begin
          ram_raddr = '0;
        end
        if (accept) begin
          case (in_if.mode)
            MODE_INSERT: begin
              res_load = 1'b1;
              if (tag_ok) begin
                ram_we             = 1'b1;
                ram_wdata.start    = SECTOR_BITS'(in_if.start_sector);
                ram_wdata.write    = in_if.is_write;
                ram_wdata.level    = in_lvl;
                ram_wdata.deadline = in_if.current_time +
                  {1'b0, (in_if.is_write ? write_exp_r : read_exp_r)};
                ram_wdata.order    = in_if.insert_at_head ? head_cnt_r : tail_cnt_r;
                ram_wdata.flags    = {in_if.is_discard, in_if.is_mergeable};
                valid_nxt[in_tag]  = 1'b1;
                res.hit            = 1'b1;
                res.tag            = in_if.request_tag;
              end
            end
            MODE_DISPATCH, MODE_LOOKUP: res_load = 1'b0;
            MODE_REMOVE: begin
              res_load = 1'b1;
              if (tag_ok && valid_r[in_tag]) begin
                valid_nxt[in_tag] = 1'b0;
                res.hit           = 1'b1;
                res.tag           = in_if.request_tag;
              end
            end
            MODE_UPDATE: res_load = !(tag_ok && valid_r[in_tag]);
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_UPD: begin
        ram_we          = 1'b1;
        ram_waddr       = tag_r;
        ram_wdata.start = start_r;
        res_load        = 1'b1;
        res.hit         = 1'b1;
        res.tag         = 6'(tag_r);
      end
      ST_SCAN: begin
        ram_raddr = idx_r + TAG_W'(1);
      end
      ST_FIN: begin
        res_load = 1'b1;
        if (mode_r == MODE_DISPATCH) begin
          if (sel_found) begin
            res.hit   = 1'b1;
            res.bydl  = expired;
            res.tag   = 6'(expired ? htag_r[sel_q] : ltag_r[sel_q]);
            valid_nxt[expired ? htag_r[sel_q] : ltag_r[sel_q]] = 1'b0;
          end
        end else if (bv_r) begin
          res.hit  = 1'b1;
          res.tag  = 6'(btag_r);
          res.kind = bdisc_r ? MERGE_DISCARD : MERGE_FRONT;
        end
      end
      default: res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      head_cnt_r    <= 32'd0;
      tail_cnt_r    <= 32'd1;
      read_exp_r    <= READ_EXPIRE_RST;
      write_exp_r   <= WRITE_EXPIRE_RST;
      fm_en_r       <= 1'b1;
      out_valid_r   <= 1'b0;
      out_pending_r <= 1'b0;
      qv_r          <= '0;
      bv_r          <= 1'b0;
      idx_r         <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_READ_EXPIRE:  read_exp_r  <= cfg_wdata;
          CFG_WRITE_EXPIRE: write_exp_r <= cfg_wdata;
          CFG_FRONT_MERGE:  fm_en_r     <= cfg_wdata[0];
          default: fm_en_r <= fm_en_r;
        endcase
      end
      if (accept && in_if.mode == MODE_INSERT && tag_ok) begin
        if (in_if.insert_at_head) begin
          head_cnt_r <= head_cnt_r - 32'd1;
        end else begin
          tail_cnt_r <= tail_cnt_r + 32'd1;
        end
      end
      if (accept) begin
        qv_r  <= '0;
        bv_r  <= 1'b0;
        idx_r <= '0;
      end
      if (state_r == ST_SCAN) begin
        idx_r <= idx_r + TAG_W'(1);
        if (ev && mode_r == MODE_DISPATCH && ram_rdata.level != 2'd3) begin
          if (!qv_r[eq] || pos < hpos_r[eq]) begin
            htag_r[eq] <= idx_r;
            hpos_r[eq] <= pos;
            hdl_r[eq]  <= ram_rdata.deadline;
          end
          if (!qv_r[eq] || ram_rdata.start < lstart_r[eq] ||
              (ram_rdata.start == lstart_r[eq] && pos < lpos_r[eq])) begin
            ltag_r[eq]   <= idx_r;
            lstart_r[eq] <= ram_rdata.start;
            lpos_r[eq]   <= pos;
          end
          qv_r[eq] <= 1'b1;
        end
        if (ev && mode_r == MODE_LOOKUP && fm_en_r && ram_rdata.write == dir_r &&
            ram_rdata.level == lvl_r && ram_rdata.start == key_r &&
            ram_rdata.flags[0] && (!bv_r || pos < bpos_r)) begin
          bv_r    <= 1'b1;
          btag_r  <= idx_r;
          bpos_r  <= pos;
          bdisc_r <= ram_rdata.flags[1];
        end
      end
      if (res_load) begin
        out_valid_r   <= 1'b1;
        out_pending_r <= |valid_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command word and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_if.mode;
      tag_r   <= in_tag;
      start_r <= SECTOR_BITS'(in_if.start_sector);
      dir_r   <= in_if.is_write;
      lvl_r   <= in_lvl;
      key_r   <= SECTOR_BITS'(in_if.lookup_sector);
      now_r   <= in_if.current_time;
    end
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.hit          = res_r.hit;
  assign out_if.out_tag      = res_r.tag;
  assign out_if.merge_kind   = res_r.kind;
  assign out_if.by_deadline  = res_r.bydl;
  assign out_if.work_pending = out_pending_r;

endmodule

// ===== hw/rtl/pdios_ram.sv =====
// pdios_ram: generic single write, single read ram with registered read.
// No dependencies.
module pdios_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
